FILE: hw/rtl/ply_binary_record_decoder_defines.svh
// Assertion macros shared by the point record decoder RTL.
// Each macro expects signals named clock and reset in the including scope.
`ifndef PLY_BINARY_RECORD_DECODER_DEFINES_SVH
`define PLY_BINARY_RECORD_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PBRD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pbrd: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PBRD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pbrd: next-cycle check failed");

`endif

FILE: hw/rtl/pbrd_pkg.sv
// Types, codes and conversion helpers for the point record decoder.
// Used by every module of the block; depends on nothing else.
package pbrd_pkg;

   // Field kind codes.
   localparam logic [3:0] KIND_X     = 4'd0;
   localparam logic [3:0] KIND_Y     = 4'd1;
   localparam logic [3:0] KIND_Z     = 4'd2;
   localparam logic [3:0] KIND_RED   = 4'd3;
   localparam logic [3:0] KIND_GREEN = 4'd4;
   localparam logic [3:0] KIND_BLUE  = 4'd5;
   localparam logic [3:0] KIND_NX    = 4'd6;
   localparam logic [3:0] KIND_NY    = 4'd7;
   localparam logic [3:0] KIND_NZ    = 4'd8;
   localparam logic [3:0] KIND_RGB   = 4'd9;
   localparam logic [3:0] KIND_RGBA  = 4'd10;
   localparam logic [3:0] KIND_LABEL = 4'd12;
   localparam logic [3:0] KIND_PART  = 4'd13;

   // Field type codes.
   localparam logic [2:0] TYPE_F32 = 3'd0;
   localparam logic [2:0] TYPE_F64 = 3'd1;
   localparam logic [2:0] TYPE_I8  = 3'd2;
   localparam logic [2:0] TYPE_I32 = 3'd3;
   localparam logic [2:0] TYPE_I64 = 3'd4;
   localparam logic [2:0] TYPE_U8  = 3'd5;
   localparam logic [2:0] TYPE_U32 = 3'd6;
   localparam logic [2:0] TYPE_U64 = 3'd7;

   // Result word slots.
   localparam int unsigned NUM_WORDS = 12;
   localparam logic [3:0] WORD_PX = 4'd0;
   localparam logic [3:0] WORD_PY = 4'd1;
   localparam logic [3:0] WORD_PZ = 4'd2;
   localparam logic [3:0] WORD_NX = 4'd3;
   localparam logic [3:0] WORD_NY = 4'd4;
   localparam logic [3:0] WORD_NZ = 4'd5;
   localparam logic [3:0] WORD_CR = 4'd6;
   localparam logic [3:0] WORD_CG = 4'd7;
   localparam logic [3:0] WORD_CB = 4'd8;
   localparam logic [3:0] WORD_CA = 4'd9;
   localparam logic [3:0] WORD_LB = 4'd10;
   localparam logic [3:0] WORD_PT = 4'd11;

   // Configuration register indexes.
   localparam logic [7:0] CSR_FIELD_COUNT = 8'd0;
   localparam logic [7:0] CSR_DESC_LO     = 8'd1;
   localparam logic [7:0] CSR_DESC_HI     = 8'd2;
   localparam logic [7:0] CSR_POINTS      = 8'd3;

   localparam logic [31:0] F32_ONE = 32'h3F80_0000;
   localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

   // Conversion operation carried down the pipeline.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_BITS,
      OP_NORM_INT,
      OP_NORM_DBL,
      OP_ID_FLT,
      OP_COLOR
   } op_type;

   // A completed field leaving the byte assembler.
   typedef struct packed {
      logic        valid;
      logic        last;
      logic [3:0]  kind;
      logic [2:0]  ftype;
      logic [63:0] acc;
   } fld_type;

   // Field after decode, before normalization.
   typedef struct packed {
      logic        valid;
      logic        last;
      op_type      op;
      logic [3:0]  word;
      logic        sign;
      logic        rgb;
      logic [7:0]  exp;
      logic [6:0]  rsh;
      logic [5:0]  lz;
      logic [63:0] mag;
      logic [31:0] bits;
   } prep_type;

   // Field after the shift stage, ready for rounding.
   typedef struct packed {
      logic        valid;
      logic        last;
      op_type      op;
      logic [3:0]  word;
      logic        sign;
      logic        rgb;
      logic [7:0]  exp;
      logic        sticky;
      logic [63:0] n;
      logic [31:0] bits;
   } shf_type;

   // Update to the point under assembly.
   typedef struct packed {
      logic        valid;
      logic        last;
      logic        single;
      logic        color;
      logic [3:0]  word;
      logic [31:0] value;
      logic [31:0] col_r;
      logic [31:0] col_g;
      logic [31:0] col_b;
      logic [31:0] col_a;
   } wr_type;

   // Assembler position, for checking.
   typedef struct packed {
      logic [3:0] field_index;
      logic [2:0] byte_in_field;
   } status_type;

   function automatic logic [3:0] type_bytes(input logic [2:0] t);
      logic [3:0] r;
      case (t)
         TYPE_F64, TYPE_I64, TYPE_U64: r = 4'd8;
         TYPE_I8, TYPE_U8:             r = 4'd1;
         default:                      r = 4'd4;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] kind_word(input logic [3:0] k);
      logic [3:0] r;
      case (k)
         KIND_X:     r = WORD_PX;
         KIND_Y:     r = WORD_PY;
         KIND_Z:     r = WORD_PZ;
         KIND_RED:   r = WORD_CR;
         KIND_GREEN: r = WORD_CG;
         KIND_BLUE:  r = WORD_CB;
         KIND_NX:    r = WORD_NX;
         KIND_NY:    r = WORD_NY;
         KIND_NZ:    r = WORD_NZ;
         default:    r = WORD_PX;
      endcase
      return r;
   endfunction

   // Seven-bit descriptor of one of eight fields in a packed word.
   function automatic logic [6:0] desc_slice(input logic [55:0] w, input logic [2:0] sel);
      return w[7*sel +: 7];
   endfunction

   function automatic logic [2:0] lzc8(input logic [7:0] v);
      logic [2:0] r;
      casez (v)
         8'b1???????: r = 3'd0;
         8'b01??????: r = 3'd1;
         8'b001?????: r = 3'd2;
         8'b0001????: r = 3'd3;
         8'b00001???: r = 3'd4;
         8'b000001??: r = 3'd5;
         8'b0000001?: r = 3'd6;
         default:     r = 3'd7;
      endcase
      return r;
   endfunction

   // Leading zero count in two levels: per byte, then the first nonzero byte.
   function automatic logic [5:0] lzc64(input logic [63:0] v);
      logic [5:0] r;
      logic       found;
      r = 6'd63;
      found = 1'b0;
      for (int g = 7; g >= 0; g--) begin
         if (!found && (|v[g*8 +: 8])) begin
            r = {3'(7 - g), lzc8(v[g*8 +: 8])};
            found = 1'b1;
         end
      end
      return r;
   endfunction

   // v / 255 as float32. In binary v/255 is the byte v repeated forever, so
   // the significand is read off the repeated pattern. The tail past the
   // round bit always holds a one, so rounding is up exactly when the round
   // bit is set. Full scale is exactly one.
   function automatic logic [31:0] div255(input logic [7:0] v);
      logic [2:0]  lz;
      logic [39:0] rep;
      logic [39:0] sh;
      logic [31:0] r;
      lz  = lzc8(v);
      rep = {5{v}};
      sh  = rep << ({1'b0, lz} + 4'd1);
      if (v == 8'd0) begin
         r = 32'd0;
      end else if (v == 8'hFF) begin
         r = F32_ONE;
      end else begin
         r = {1'b0, 8'd126 - {5'd0, lz}, sh[39:17]} + {31'd0, sh[16]};
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/pbrd_assembler.sv
// Byte assembler: configuration registers, field walk and point count.
// Gathers big-endian bytes into fields; depends on pbrd_pkg.
module pbrd_assembler #(
   parameter int MAX_FIELDS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   req_valid,
   input  logic [7:0]             req_data_byte,
   input  logic                   csr_valid,
   input  logic [7:0]             csr_index,
   input  logic [63:0]            csr_wdata,
   output logic                   clear_point,
   output pbrd_pkg::fld_type      fld_o,
   output pbrd_pkg::status_type   stat_o
);
   import pbrd_pkg::*;

   logic [4:0]  field_count_ff;
   logic [55:0] desc_lo_ff;
   logic [55:0] desc_hi_ff;
   logic [31:0] points_expected_ff;
   logic [31:0] points_done_ff, points_done_in;
   logic [3:0]  field_index_ff, field_index_in;
   logic [2:0]  byte_in_field_ff, byte_in_field_in;
   logic [63:0] acc_ff, acc_in;
   fld_type     fld_ff, fld_in;

   logic [4:0]  count;
   logic        running;
   logic        accept;
   logic [6:0]  desc;
   logic [63:0] acc_next;
   logic [3:0]  bif_inc;
   logic [4:0]  idx_inc;
   logic        field_end;
   logic        point_end;

   // Active field count and whether decoding still runs.
   assign count   = (field_count_ff > 5'(MAX_FIELDS)) ? 5'(MAX_FIELDS) : field_count_ff;
   assign running = (count != 5'd0) && (points_done_ff < points_expected_ff);
   assign accept  = req_valid && advance;

   // Descriptor of the current field and progress through it.
   assign desc      = field_index_ff[3] ? desc_slice(desc_hi_ff, field_index_ff[2:0])
                                        : desc_slice(desc_lo_ff, field_index_ff[2:0]);
   assign acc_next  = {acc_ff[55:0], req_data_byte};
   assign bif_inc   = {1'b0, byte_in_field_ff} + 4'd1;
   assign idx_inc   = {1'b0, field_index_ff} + 5'd1;
   assign field_end = (bif_inc == type_bytes(desc[2:0]));
   assign point_end = (idx_inc == count);

   // A write to the format registers abandons the point under assembly.
   assign clear_point = csr_valid && ((csr_index == CSR_FIELD_COUNT) ||
                                      (csr_index == CSR_DESC_LO) ||
                                      (csr_index == CSR_DESC_HI));

   // Next state of the field walk.
   always_comb begin
      field_index_in   = field_index_ff;
      byte_in_field_in = byte_in_field_ff;
      acc_in           = acc_ff;
      points_done_in   = points_done_ff;
      if (clear_point) begin
         field_index_in   = 4'd0;
         byte_in_field_in = 3'd0;
         acc_in           = 64'd0;
      end else if (accept && running) begin
         if (field_end) begin
            acc_in           = 64'd0;
            byte_in_field_in = 3'd0;
            if (point_end) begin
               field_index_in = 4'd0;
               points_done_in = points_done_ff + 32'd1;
            end else begin
               field_index_in = idx_inc[3:0];
            end
         end else begin
            acc_in           = acc_next;
            byte_in_field_in = bif_inc[2:0];
         end
      end
   end

   // Completed field word for the conversion pipeline.
   always_comb begin
      fld_in       = fld_ff;
      fld_in.valid = accept && running && field_end && !clear_point;
      fld_in.last  = point_end;
      fld_in.kind  = desc[6:3];
      fld_in.ftype = desc[2:0];
      fld_in.acc   = acc_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_count_ff     <= 5'd0;
         desc_lo_ff         <= 56'd0;
         desc_hi_ff         <= 56'd0;
         points_expected_ff <= 32'd0;
         points_done_ff     <= 32'd0;
         field_index_ff     <= 4'd0;
         byte_in_field_ff   <= 3'd0;
         acc_ff             <= 64'd0;
         fld_ff.valid       <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_FIELD_COUNT: field_count_ff     <= csr_wdata[4:0];
               CSR_DESC_LO:     desc_lo_ff         <= csr_wdata[55:0];
               CSR_DESC_HI:     desc_hi_ff         <= csr_wdata[55:0];
               CSR_POINTS:      points_expected_ff <= csr_wdata[31:0];
               default:         ;
            endcase
         end
         points_done_ff   <= points_done_in;
         field_index_ff   <= field_index_in;
         byte_in_field_ff <= byte_in_field_in;
         acc_ff           <= acc_in;
         if (advance) begin
            fld_ff <= fld_in;
         end
      end
   end

   assign fld_o  = fld_ff;
   assign stat_o = '{field_index: field_index_ff, byte_in_field: byte_in_field_ff};

endmodule

FILE: hw/rtl/pbrd_convert.sv
// Conversion pipeline: decode, leading zero count and alignment shift.
// Three register stages between the assembler and rounding; uses pbrd_pkg.
module pbrd_convert (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  pbrd_pkg::fld_type fld_i,
   output pbrd_pkg::shf_type shf_o
);
   import pbrd_pkg::*;

   prep_type s2_ff, s2_in;
   prep_type s3_ff, s3_in;
   shf_type  s4_ff, s4_in;

   logic [63:0]        ival;
   logic               ineg;
   logic [63:0]        imag;
   logic               ds;
   logic [10:0]        de;
   logic [51:0]        df;
   logic signed [12:0] dbe;
   logic signed [12:0] dneg;
   logic               dnan;
   logic               fs;
   logic [7:0]         fe;
   logic [22:0]        fm;
   logic               fnan;
   logic [7:0]         frsh;
   logic [10:0]        drsh;
   logic [63:0]        rmask;

   // Stage 2: split the field by kind and type.
   always_comb begin
      case (fld_i.ftype)
         TYPE_I8: begin
            ival = {{56{fld_i.acc[7]}}, fld_i.acc[7:0]};
            ineg = fld_i.acc[7];
         end
         TYPE_I32: begin
            ival = {{32{fld_i.acc[31]}}, fld_i.acc[31:0]};
            ineg = fld_i.acc[31];
         end
         TYPE_I64: begin
            ival = fld_i.acc;
            ineg = fld_i.acc[63];
         end
         TYPE_U8: begin
            ival = {56'd0, fld_i.acc[7:0]};
            ineg = 1'b0;
         end
         TYPE_U32: begin
            ival = {32'd0, fld_i.acc[31:0]};
            ineg = 1'b0;
         end
         default: begin
            ival = fld_i.acc;
            ineg = 1'b0;
         end
      endcase
      imag = ineg ? (~ival + 64'd1) : ival;

      ds   = fld_i.acc[63];
      de   = fld_i.acc[62:52];
      df   = fld_i.acc[51:0];
      dnan = (de == 11'h7FF) && (df != 52'd0);
      dbe  = $signed({2'b00, de}) - 13'sd896;
      dneg = 13'sd1 - dbe;
      drsh = 11'd1086 - de;

      fs   = fld_i.acc[31];
      fe   = fld_i.acc[30:23];
      fm   = fld_i.acc[22:0];
      fnan = (fe == 8'hFF) && (fm != 23'd0);
      frsh = 8'd190 - fe;

      s2_in       = '0;
      s2_in.valid = fld_i.valid;
      s2_in.last  = fld_i.last;
      s2_in.op    = OP_NONE;

      if (fld_i.kind <= KIND_NZ) begin
         // Numeric kinds become float32.
         s2_in.word = kind_word(fld_i.kind);
         case (fld_i.ftype)
            TYPE_F32: begin
               s2_in.op   = OP_BITS;
               s2_in.bits = fld_i.acc[31:0];
            end
            TYPE_F64: begin
               s2_in.op = OP_BITS;
               if (de == 11'h7FF) begin
                  s2_in.bits = dnan ? {ds, 8'hFF, 1'b1, df[50:29]} : {ds, 8'hFF, 23'd0};
               end else if (de == 11'd0) begin
                  s2_in.bits = {ds, 31'd0};
               end else if (dbe >= 13'sd255) begin
                  s2_in.bits = {ds, 8'hFF, 23'd0};
               end else begin
                  s2_in.op   = OP_NORM_DBL;
                  s2_in.sign = ds;
                  s2_in.mag  = {1'b1, df, 11'd0};
                  if (dbe >= 13'sd1) begin
                     s2_in.exp = dbe[7:0];
                     s2_in.rsh = 7'd0;
                  end else begin
                     // Result is subnormal: shift right and hold the exponent.
                     s2_in.exp = 8'd1;
                     s2_in.rsh = (dneg >= 13'sd64) ? 7'd64 : dneg[6:0];
                  end
               end
            end
            default: begin
               if (ival == 64'd0) begin
                  s2_in.op   = OP_BITS;
                  s2_in.bits = 32'd0;
               end else begin
                  s2_in.op   = OP_NORM_INT;
                  s2_in.sign = ineg;
                  s2_in.mag  = imag;
               end
            end
         endcase
      end else if ((fld_i.kind == KIND_RGB) || (fld_i.kind == KIND_RGBA)) begin
         // Packed color only with a four-byte type.
         if (type_bytes(fld_i.ftype) == 4'd4) begin
            s2_in.op   = OP_COLOR;
            s2_in.bits = fld_i.acc[31:0];
            s2_in.rgb  = (fld_i.kind == KIND_RGB);
         end
      end else if ((fld_i.kind == KIND_LABEL) || (fld_i.kind == KIND_PART)) begin
         // Identifiers: truncate toward zero and saturate to 32 bits.
         s2_in.word = (fld_i.kind == KIND_LABEL) ? WORD_LB : WORD_PT;
         s2_in.op   = OP_BITS;
         case (fld_i.ftype)
            TYPE_F32: begin
               if (fs || fnan || (fe < 8'd127)) begin
                  s2_in.bits = 32'd0;
               end else if (fe >= 8'd159) begin
                  s2_in.bits = U32_MAX;
               end else begin
                  s2_in.op  = OP_ID_FLT;
                  s2_in.mag = {1'b1, fm, 40'd0};
                  s2_in.rsh = frsh[6:0];
               end
            end
            TYPE_F64: begin
               if (ds || dnan || (de < 11'd1023)) begin
                  s2_in.bits = 32'd0;
               end else if (de >= 11'd1055) begin
                  s2_in.bits = U32_MAX;
               end else begin
                  s2_in.op  = OP_ID_FLT;
                  s2_in.mag = {1'b1, df, 11'd0};
                  s2_in.rsh = drsh[6:0];
               end
            end
            default: begin
               if (ineg) begin
                  s2_in.bits = 32'd0;
               end else if (|ival[63:32]) begin
                  s2_in.bits = U32_MAX;
               end else begin
                  s2_in.bits = ival[31:0];
               end
            end
         endcase
      end
   end

   // Stage 3: leading zero count of integer magnitudes.
   always_comb begin
      s3_in    = s2_ff;
      s3_in.lz = lzc64(s2_ff.mag);
   end

   // Stage 4: normalize integers left, align doubles and identifiers right.
   always_comb begin
      s4_in.valid = s3_ff.valid;
      s4_in.last  = s3_ff.last;
      s4_in.op    = s3_ff.op;
      s4_in.word  = s3_ff.word;
      s4_in.sign  = s3_ff.sign;
      s4_in.rgb   = s3_ff.rgb;
      s4_in.bits  = s3_ff.bits;
      rmask       = ~({64{1'b1}} << s3_ff.rsh[5:0]);
      if (s3_ff.op == OP_NORM_INT) begin
         s4_in.n      = s3_ff.mag << s3_ff.lz;
         s4_in.exp    = 8'd190 - {2'b00, s3_ff.lz};
         s4_in.sticky = 1'b0;
      end else if (s3_ff.rsh[6]) begin
         s4_in.n      = 64'd0;
         s4_in.exp    = s3_ff.exp;
         s4_in.sticky = |s3_ff.mag;
      end else begin
         s4_in.n      = s3_ff.mag >> s3_ff.rsh[5:0];
         s4_in.exp    = s3_ff.exp;
         s4_in.sticky = |(s3_ff.mag & rmask);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else if (advance) begin
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   assign shf_o = s4_ff;

endmodule

FILE: hw/rtl/pbrd_pack.sv
// Rounding and packing: turns an aligned field into result word updates.
// Round to nearest even, plus the packed color scaling; uses pbrd_pkg.
module pbrd_pack (
   input  pbrd_pkg::shf_type shf_i,
   output pbrd_pkg::wr_type  wr_o
);
   import pbrd_pkg::*;

   logic [23:0] mant;
   logic        rnd;
   logic        sticky;
   logic        up;
   logic [30:0] mag31;

   // Round to nearest, ties to even; a carry runs into the exponent.
   assign mant   = shf_i.n[63:40];
   assign rnd    = shf_i.n[39];
   assign sticky = (|shf_i.n[38:0]) || shf_i.sticky;
   assign up     = rnd && (sticky || mant[0]);
   assign mag31  = {shf_i.exp - 8'd1, 23'd0} + {7'd0, mant} + {30'd0, up};

   // Select the update for the point under assembly.
   always_comb begin
      wr_o        = '0;
      wr_o.valid  = shf_i.valid;
      wr_o.last   = shf_i.last;
      wr_o.word   = shf_i.word;
      wr_o.col_r  = div255(shf_i.bits[31:24]);
      wr_o.col_g  = div255(shf_i.bits[23:16]);
      wr_o.col_b  = div255(shf_i.bits[15:8]);
      wr_o.col_a  = shf_i.rgb ? F32_ONE : div255(shf_i.bits[7:0]);
      case (shf_i.op)
         OP_BITS: begin
            wr_o.single = 1'b1;
            wr_o.value  = shf_i.bits;
         end
         OP_NORM_INT, OP_NORM_DBL: begin
            wr_o.single = 1'b1;
            wr_o.value  = {shf_i.sign, mag31};
         end
         OP_ID_FLT: begin
            wr_o.single = 1'b1;
            wr_o.value  = shf_i.n[31:0];
         end
         OP_COLOR: begin
            wr_o.color = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

FILE: hw/rtl/pbrd_record.sv
// Point record: holds the twelve result words and the result register.
// Emits a record when the last field of a point arrives; uses pbrd_pkg.
module pbrd_record (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             clear_point,
   input  pbrd_pkg::wr_type wr_i,
   output logic             rsp_valid,
   output logic [31:0]      rsp_pos_x,
   output logic [31:0]      rsp_pos_y,
   output logic [31:0]      rsp_pos_z,
   output logic [31:0]      rsp_norm_x,
   output logic [31:0]      rsp_norm_y,
   output logic [31:0]      rsp_norm_z,
   output logic [31:0]      rsp_col_r,
   output logic [31:0]      rsp_col_g,
   output logic [31:0]      rsp_col_b,
   output logic [31:0]      rsp_col_a,
   output logic [31:0]      rsp_label_id,
   output logic [31:0]      rsp_part_id
);
   import pbrd_pkg::*;

   logic [31:0] point_ff [NUM_WORDS];
   logic [31:0] point_in [NUM_WORDS];
   logic [31:0] rec_ff   [NUM_WORDS];
   logic        rsp_valid_ff;

   // Merge this cycle's update into the point words.
   always_comb begin
      point_in = point_ff;
      if (wr_i.single) begin
         point_in[wr_i.word] = wr_i.value;
      end
      if (wr_i.color) begin
         point_in[WORD_CR] = wr_i.col_r;
         point_in[WORD_CG] = wr_i.col_g;
         point_in[WORD_CB] = wr_i.col_b;
         point_in[WORD_CA] = wr_i.col_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_WORDS; i++) begin
            point_ff[i] <= 32'd0;
         end
      end else begin
         if (advance) begin
            rsp_valid_ff <= wr_i.valid && wr_i.last;
         end
         if (clear_point) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
               point_ff[i] <= 32'd0;
            end
         end else if (advance && wr_i.valid) begin
            if (wr_i.last) begin
               for (int i = 0; i < NUM_WORDS; i++) begin
                  point_ff[i] <= 32'd0;
               end
            end else begin
               point_ff <= point_in;
            end
         end
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (advance && wr_i.valid && wr_i.last) begin
         rec_ff <= point_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pos_x    = rec_ff[WORD_PX];
   assign rsp_pos_y    = rec_ff[WORD_PY];
   assign rsp_pos_z    = rec_ff[WORD_PZ];
   assign rsp_norm_x   = rec_ff[WORD_NX];
   assign rsp_norm_y   = rec_ff[WORD_NY];
   assign rsp_norm_z   = rec_ff[WORD_NZ];
   assign rsp_col_r    = rec_ff[WORD_CR];
   assign rsp_col_g    = rec_ff[WORD_CG];
   assign rsp_col_b    = rec_ff[WORD_CB];
   assign rsp_col_a    = rec_ff[WORD_CA];
   assign rsp_label_id = rec_ff[WORD_LB];
   assign rsp_part_id  = rec_ff[WORD_PT];

endmodule

FILE: hw/rtl/ply_binary_record_decoder.sv
// Big-endian binary point record decoder: one byte word accepted per cycle.
// Path of the last byte of a point: assembler, decode, zero count, shift,
// then round into the result register, which makes the record valid.
// Throughput: one byte per cycle; the pipeline stalls only while a record
// waits in the result register. Synchronous reset clears configuration,
// counters, the point under assembly and all valid bits.
`include "ply_binary_record_decoder_defines.svh"

module ply_binary_record_decoder #(
   parameter int MAX_FIELDS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pos_x,
   output logic [31:0] rsp_pos_y,
   output logic [31:0] rsp_pos_z,
   output logic [31:0] rsp_norm_x,
   output logic [31:0] rsp_norm_y,
   output logic [31:0] rsp_norm_z,
   output logic [31:0] rsp_col_r,
   output logic [31:0] rsp_col_g,
   output logic [31:0] rsp_col_b,
   output logic [31:0] rsp_col_a,
   output logic [31:0] rsp_label_id,
   output logic [31:0] rsp_part_id,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import pbrd_pkg::*;

   logic       advance;
   logic       clear_point;
   fld_type    fld;
   shf_type    shf;
   wr_type     wr;
   status_type stat;

   // Whole pipeline moves unless a record is held in the result register.
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   pbrd_assembler #(
      .MAX_FIELDS (MAX_FIELDS)
   ) u_assembler (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .clear_point   (clear_point),
      .fld_o         (fld),
      .stat_o        (stat)
   );

   pbrd_convert u_convert (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .fld_i   (fld),
      .shf_o   (shf)
   );

   pbrd_pack u_pack (
      .shf_i (shf),
      .wr_o  (wr)
   );

   pbrd_record u_record (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .clear_point  (clear_point),
      .wr_i         (wr),
      .rsp_valid    (rsp_valid),
      .rsp_pos_x    (rsp_pos_x),
      .rsp_pos_y    (rsp_pos_y),
      .rsp_pos_z    (rsp_pos_z),
      .rsp_norm_x   (rsp_norm_x),
      .rsp_norm_y   (rsp_norm_y),
      .rsp_norm_z   (rsp_norm_z),
      .rsp_col_r    (rsp_col_r),
      .rsp_col_g    (rsp_col_g),
      .rsp_col_b    (rsp_col_b),
      .rsp_col_a    (rsp_col_a),
      .rsp_label_id (rsp_label_id),
      .rsp_part_id  (rsp_part_id)
   );

   // A new record only follows the last field of a point leaving the shift stage.
   `PBRD_ASSERT_SAME(a_rec_from_last, $rose(rsp_valid), $past(shf.valid && shf.last))
   // A stalled field in the shift stage is not dropped.
   `PBRD_ASSERT_NEXT(a_stall_holds, !advance && shf.valid, shf.valid)
   // A format write restarts the field walk.
   `PBRD_ASSERT_NEXT(a_fmt_clears,
      csr_valid && csr_ready && ((csr_index == CSR_FIELD_COUNT) ||
      (csr_index == CSR_DESC_LO) || (csr_index == CSR_DESC_HI)),
      (stat.field_index == 4'd0) && (stat.byte_in_field == 3'd0))

endmodule
